/* rtl/ttrm_pkg.sv */
// ----------------------------------------------------------------------------
// ttrm_pkg
// Types and constants for the max winner tree.
// ----------------------------------------------------------------------------
package ttrm_pkg;

  localparam int LEAF_COUNT  = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(LEAF_COUNT);
  localparam int NODE_W      = IDX_W + 1;
  localparam int NODE_COUNT  = 2 * LEAF_COUNT;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REPLACE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATCH
  } state_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [IDX_W-1:0]        leaf_index;
    logic [VALUE_WIDTH-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]  old_top_value;
    logic [VALUE_WIDTH-1:0]  top_value;
    logic [IDX_W-1:0]        top_leaf;
  } out_item_t;

  // One tree node: winning leaf and a copy of its value.
  typedef struct packed {
    logic [IDX_W-1:0]        leaf;
    logic [VALUE_WIDTH-1:0]  value;
  } entry_t;

  localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Leftmost leaf below node n (leaves are nodes LEAF_COUNT and up).
  function automatic logic [IDX_W-1:0] leftmost_leaf(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n;
    for (int i = 0; i < IDX_W; i++) begin
      if (m < NODE_W'(LEAF_COUNT)) begin
        m = m << 1;
      end
    end
    return m[IDX_W-1:0];
  endfunction

endpackage

/* rtl/tournament_tree_replace_max.sv */
// ----------------------------------------------------------------------------
// tournament_tree_replace_max
// Max winner tree over LEAF_COUNT signed leaves with load and replace-top.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transfer happens at a rising edge with start high and busy low.
//   cmd LOAD writes in_data.value to leaf in_data.leaf_index; cmd REPLACE
//   writes it to the leaf that currently wins at the root (leaf_index unused).
//   Result: out_valid is high for exactly one cycle with the old top (replace
//   only, else zero), the new top value and the leaf holding it. The receiver
//   cannot stall; each result must be taken in the cycle it is shown.
//   Timing: after the accept edge the block replays one match per cycle up
//   the path from the leaf to the root, bounded by the single read port of
//   the node memory (one sibling read per level). out_valid rises in the
//   cycle after the last match and busy is low again in that same cycle;
//   busy stays high until then, so no new item is taken before the result.
//   Reset: a clearing pass writes every node memory entry, one per cycle,
//   with busy high; then all leaves hold the most negative value and leaf 0
//   is the top.
// Structure:
//   One memory of 2*LEAF_COUNT entries; inner node n has children 2n, 2n+1,
//   leaf k sits at node LEAF_COUNT+k. Each entry keeps its winning leaf and
//   a copy of that leaf's value, so a match needs a single sibling read.
//   The root is mirrored in top_r for the replace lookup.
// ----------------------------------------------------------------------------
module tournament_tree_replace_max (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ttrm_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ttrm_pkg::out_item_t out_data
);
  import ttrm_pkg::*;

  // node memory
  entry_t            mem [NODE_COUNT];
  logic              we;
  logic [NODE_W-1:0] waddr;
  entry_t            wdata;
  logic [NODE_W-1:0] raddr;
  entry_t            rdata_r;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;    // node on the path just updated
  entry_t            cur_r, cur_nxt;      // winner of node_r
  entry_t            top_r, top_nxt;      // mirror of the root
  logic [VALUE_WIDTH-1:0] old_top_r, old_top_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic [IDX_W-1:0]  wr_leaf;
  logic [NODE_W-1:0] parent;
  logic              path_wins;
  entry_t            win;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign parent = node_r >> 1;

  // Ties go left: on the left the path child wins ties, on the right it loses them.
  always_comb begin
    if (!node_r[0]) begin
      path_wins = $signed(cur_r.value) >= $signed(rdata_r.value);
    end else begin
      path_wins = $signed(cur_r.value) > $signed(rdata_r.value);
    end
    win = path_wins ? cur_r : rdata_r;
  end

  assign wr_leaf = (in_data.cmd == CMD_REPLACE) ? top_r.leaf : in_data.leaf_index;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    top_nxt       = top_r;
    old_top_nxt   = old_top_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = clr_r;
    wdata         = '{leaf: leftmost_leaf(clr_r), value: MOST_NEG};
    raddr         = node_r ^ NODE_W'(1);
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        clr_nxt = clr_r + NODE_W'(1);
        if (clr_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          // write the leaf and fetch its sibling
          we          = 1'b1;
          waddr       = {1'b1, wr_leaf};
          wdata       = '{leaf: wr_leaf, value: in_data.value};
          raddr       = {1'b1, wr_leaf} ^ NODE_W'(1);
          node_nxt    = {1'b1, wr_leaf};
          cur_nxt     = wdata;
          old_top_nxt = (in_data.cmd == CMD_REPLACE) ? top_r.value : '0;
          state_nxt   = ST_MATCH;
        end
      end
      ST_MATCH: begin
        we       = 1'b1;
        waddr    = parent;
        wdata    = win;
        raddr    = parent ^ NODE_W'(1);
        node_nxt = parent;
        cur_nxt  = win;
        if (parent == NODE_W'(1)) begin
          top_nxt       = win;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{old_top_value: old_top_r, top_value: win.value,
                            top_leaf: win.leaf};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      top_r       <= '{leaf: '0, value: MOST_NEG};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    cur_r      <= cur_nxt;
    old_top_r  <= old_top_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low after accept");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  a_top_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.top_leaf == top_r.leaf) && (out_data.top_value == top_r.value))
    else $error("root mirror out of step with result");

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("not clearing after reset");
`endif

endmodule

/* verif/tournament_tree_replace_max_tb.sv */
// ----------------------------------------------------------------------------
// tournament_tree_replace_max_tb
// Self-checking bench for the max winner tree with load and replace-top.
// A short table of directed transfers covers the extremes and tie cases.
// Selection bursts (fill all leaves, then pull the top repeatedly) and noise
// follow. Every result is checked field by field against the typed-in result
// where a row gives one, else against a behavioral copy of the bench leaves.
// ----------------------------------------------------------------------------
module tournament_tree_replace_max_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ttrm_pkg::*;

  localparam int RAND_ITEMS  = 1250;
  localparam int IDLE_PCT    = 24;
  localparam int SETTLE_CYC  = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS    = 24;

  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = ~MOST_NEG;

  // One directed row: the transfer, and a typed-in result where it is obvious.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // fresh tree: load the most negative value, tie keeps leaf 0 on top
    '{'{CMD_LOAD,    4'd5,  MOST_NEG},      1'b1, '{'0, MOST_NEG, 4'd0}},
    // replace with an equal value, leaf_index is ignored
    '{'{CMD_REPLACE, 4'd15, MOST_NEG},      1'b1, '{MOST_NEG, MOST_NEG, 4'd0}},
    '{'{CMD_LOAD,    4'd15, VAL_MAX},       1'b1, '{'0, VAL_MAX, 4'd15}},
    // equal maxima: left child wins, lowest leaf reported
    '{'{CMD_LOAD,    4'd0,  VAL_MAX},       1'b1, '{'0, VAL_MAX, 4'd0}},
    '{'{CMD_REPLACE, 4'd15, VAL_MAX},       1'b1, '{VAL_MAX, VAL_MAX, 4'd0}},
    '{'{CMD_REPLACE, 4'd0,  MOST_NEG},      1'b1, '{VAL_MAX, VAL_MAX, 4'd15}},
    '{'{CMD_REPLACE, 4'd0,  32'h0000_0000}, 1'b1, '{VAL_MAX, '0, 4'd15}},
    '{'{CMD_LOAD,    4'd8,  32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd7,  32'h0000_0000}, 1'b0, '0},
    // replace with a value larger than the old maximum
    '{'{CMD_REPLACE, 4'd0,  32'h0000_0001}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd10, 32'hAAAA_AAAA}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd5,  32'h5555_5555}, 1'b0, '0},
    '{'{CMD_REPLACE, 4'd15, 32'h8000_0001}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd3,  32'h7FFF_FFFE}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd12, 32'h7FFF_FFFE}, 1'b0, '0},
    '{'{CMD_REPLACE, 4'd0,  32'h7FFF_FFFF}, 1'b0, '0},
    '{'{CMD_REPLACE, 4'd0,  32'h0000_0000}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd1,  32'hFFFF_FFFF}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd14, 32'hFFFF_0000}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd2,  32'h0000_FFFF}, 1'b0, '0},
    '{'{CMD_LOAD,    4'd9,  32'h8000_0000}, 1'b0, '0},
    '{'{CMD_REPLACE, 4'd10, 32'h1234_5678}, 1'b0, '0},
    '{'{CMD_REPLACE, 4'd5,  32'h8000_0000}, 1'b0, '0},
    '{'{CMD_REPLACE, 4'd0,  32'h8000_0000}, 1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  // Bench copy of the leaves; the tree winner is recomputed from it.
  logic signed [VALUE_WIDTH-1:0] leaf_val [LEAF_COUNT];
  out_item_t pending_tops [$];

  int  err_count  = 0;
  int  n_load     = 0;
  int  n_replace  = 0;
  int  n_checked  = 0;
  int  cycle_count = 0;
  bit  idle_ok    = 1'b1;

  tournament_tree_replace_max u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Run limit; covers the clear pass, max gaps and every transfer.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[tournament_tree_replace_max] ERROR");
      $finish;
    end
  end

  // Leaf that wins at the root: highest value, lowest index on a tie
  // (the left child wins every tied match, so the full tree reduces to this).
  function automatic logic [IDX_W-1:0] leading_leaf();
    logic [IDX_W-1:0] best;
    best = '0;
    for (int i = 1; i < LEAF_COUNT; i++) begin
      if (leaf_val[i] > leaf_val[best]) begin
        best = IDX_W'(i);
      end
    end
    return best;
  endfunction

  // Applies one transfer to the bench leaves and returns the expected result.
  function automatic out_item_t tree_update(input in_item_t it);
    out_item_t r;
    logic [IDX_W-1:0] w;
    r = '0;
    if (it.cmd == CMD_REPLACE) begin
      w = leading_leaf();
      r.old_top_value = leaf_val[w];
      leaf_val[w] = it.value;
    end else begin
      // leaf_index is IDX_W bits wide, so every load is in range here
      leaf_val[it.leaf_index] = it.value;
    end
    w = leading_leaf();
    r.top_value = leaf_val[w];
    r.top_leaf  = w;
    return r;
  endfunction

  // Value mix: extremes, a narrow band around zero for ties, full range.
  function automatic logic [VALUE_WIDTH-1:0] draw_value(input bit narrow);
    int sel;
    int pick;
    sel  = $urandom_range(99);
    pick = $urandom_range(3);
    if (sel < 12) begin
      if (pick == 0) return MOST_NEG;
      else if (pick == 1) return VAL_MAX;
      else if (pick == 2) return '0;
      else return '1;
    end
    if (narrow || sel < 35) begin
      return VALUE_WIDTH'(int'($urandom_range(16)) - 8);
    end
    return VALUE_WIDTH'($urandom());
  endfunction

  // Drives one transfer and waits for it to be taken. start is left high on
  // return so back-to-back transfers never drop it; an idle gap, when
  // drawn, lowers it first in this same step (one assignment per step).
  task automatic push_transfer(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    int gap;
    if (idle_ok && ($urandom_range(99) < IDLE_PCT)) begin
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    // transfer accepted at this edge
    predicted = tree_update(it);
    pending_tops.push_back(typed ? want : predicted);
    if (it.cmd == CMD_REPLACE) n_replace++;
    else n_load++;
  endtask

  // Result checker: the receiver cannot stall, so every strobe is a transfer.
  always @(posedge clk) begin
    out_item_t exp_top;
    if (rst_n && out_valid) begin
      if (pending_tops.size() == 0) begin
        $display("%0t: result with nothing expected: old %h top %h leaf %0d", $realtime,
                 out_data.old_top_value, out_data.top_value, out_data.top_leaf);
        err_count++;
      end else begin
        exp_top = pending_tops.pop_front();
        n_checked++;
        if (out_data.old_top_value !== exp_top.old_top_value) begin
          $display("%0t: old_top_value expected %h got %h", $realtime,
                   exp_top.old_top_value, out_data.old_top_value);
          err_count++;
        end
        if (out_data.top_value !== exp_top.top_value) begin
          $display("%0t: top_value expected %h got %h", $realtime,
                   exp_top.top_value, out_data.top_value);
          err_count++;
        end
        if (out_data.top_leaf !== exp_top.top_leaf) begin
          $display("%0t: top_leaf expected %0d got %0d", $realtime,
                   exp_top.top_leaf, out_data.top_leaf);
          err_count++;
        end
      end
    end
  end

  initial begin
    in_item_t it;
    int       rand_sent;
    int       nrep;
    int       base;
    bit       narrow;
    bit       paused;

    for (int i = 0; i < LEAF_COUNT; i++) leaf_val[i] = MOST_NEG;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // the block clears its node memory after reset; the handshake waits it out

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      push_transfer(DIR_TAB[r].item, DIR_TAB[r].typed, DIR_TAB[r].want);
    end

    // Hold off until the directed results are all in.
    start <= 1'b0;
    while (pending_tops.size() != 0) @(posedge clk);

    // Random part: mostly selection bursts (load every leaf, then pull the top
    // a number of times, draining with the most negative value or refilling),
    // the rest short runs of arbitrary transfers.
    rand_sent = 0;
    paused    = 1'b0;
    while (rand_sent < RAND_ITEMS) begin
      idle_ok = !(rand_sent >= 300 && rand_sent < 550);  // back-to-back stretch
      if (!paused && rand_sent >= 600) begin
        // second pressure point, mid-run
        start <= 1'b0;
        while (pending_tops.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      if ($urandom_range(99) < 55) begin
        narrow = 1'($urandom_range(1));
        base   = $urandom_range(LEAF_COUNT - 1);
        for (int k = 0; k < LEAF_COUNT; k++) begin
          it.cmd        = CMD_LOAD;
          it.leaf_index = IDX_W'(base + k);
          it.value      = draw_value(narrow);
          push_transfer(it, 1'b0, '0);
          rand_sent++;
        end
        nrep = $urandom_range(1, LEAF_COUNT);
        for (int k = 0; k < nrep; k++) begin
          it.cmd        = CMD_REPLACE;
          it.leaf_index = IDX_W'($urandom_range(LEAF_COUNT - 1));
          it.value      = ($urandom_range(1) == 0) ? MOST_NEG : draw_value(narrow);
          push_transfer(it, 1'b0, '0);
          rand_sent++;
        end
      end else begin
        nrep = $urandom_range(1, 12);
        for (int k = 0; k < nrep; k++) begin
          it.cmd        = ($urandom_range(99) < 50) ? CMD_LOAD : CMD_REPLACE;
          it.leaf_index = IDX_W'($urandom_range(LEAF_COUNT - 1));
          it.value      = draw_value(1'b0);
          push_transfer(it, 1'b0, '0);
          rand_sent++;
        end
      end
    end

    // Drain: everything sent, wait for the last results, then keep watching to
    // catch any stray strobe.
    start <= 1'b0;
    while (pending_tops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Covered %0d loads and %0d top replacements over %0d leaves,", n_load,
             n_replace, LEAF_COUNT);
    $display("with ties, signed extremes and drain runs; %0d results checked.", n_checked);
    if (err_count == 0) begin
      $display("[tournament_tree_replace_max] OK");
    end else begin
      $display("[tournament_tree_replace_max] ERROR");
    end
    $finish;
  end

endmodule
